### rtl/kldg_pkg.sv
// kldg_pkg: shared types, constants and the log table builder for the KL loss block.
// Used by every other file under rtl; depends on nothing.
`default_nettype none

package kldg_pkg;

   localparam int LN_TABLE_BITS_DEF = 8;
   localparam int FRAC_BITS_DEF     = 15;

   localparam int IN_W    = 16;     // P and Q width
   localparam int IN_FRAC = 15;     // P and Q fraction bits
   localparam int LN_W    = 29;     // ln value and ln difference, signed
   localparam int TAB_W   = 24;     // table entry, unsigned, 24 fraction bits
   localparam int PROD_W  = 46;     // P * (ln P - ln Q), signed
   localparam int TERM_W  = 31;     // product shifted down by IN_FRAC
   localparam int GRAD_W  = 32;
   localparam int LOSS_W  = 48;

   localparam logic [23:0] LN2_Q24 = 24'd11629080;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam logic [LOSS_W-1:0] LOSS_MAX = {1'b0, {(LOSS_W-1){1'b1}}};
   localparam logic [LOSS_W-1:0] LOSS_MIN = {1'b1, {(LOSS_W-1){1'b0}}};
   localparam logic [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LNP,
      ST_LNQ,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;     // latch a new word, start the divider
      logic ln_p;     // ln(P) into its register
      logic ln_q;     // ln(P) - ln(Q) into the difference register
      logic mul;      // P * difference
      logic commit;   // update loss state, load the result register
   } cmd_type;

   typedef struct packed {
      logic skip;     // P or Q is zero: no log or quotient needed
      logic div_done;
      logic out_free; // result register can take a word this cycle
   } sts_type;

   // ln(1 + k / 2^n) with 24 fraction bits; evaluated at elaboration only.
   // log2 by repeated squaring, then scaled by ln 2 and rounded.
   function automatic logic [TAB_W-1:0] ln_entry(input int unsigned k, input int unsigned n);
      logic [63:0] y;
      logic [63:0] r;
      logic [63:0] t;
      y = (64'd1 << 30) + (64'(k) << (30 - n));
      r = 64'd0;
      for (int i = 0; i < 28; i++) begin
         y = (y * y) >> 30;
         r = r << 1;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            r = r | 64'd1;
         end
      end
      t = (r * 64'(LN2_Q32) + (64'd1 << 35)) >> 36;
      return t[TAB_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/kldg_div.sv
// kldg_div: restoring divider, one quotient bit per cycle, for (P << FRAC_BITS) / Q.
// Depends on kldg_pkg.
`default_nettype none

module kldg_div #(
   parameter int FRAC_BITS = kldg_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [kldg_pkg::IN_W-1:0]            dividend_p,
   input  wire logic [kldg_pkg::IN_W-1:0]            divisor_q,
   output logic      [kldg_pkg::IN_W+FRAC_BITS-1:0]  quotient,
   output logic                                      done
);

   localparam int DW   = kldg_pkg::IN_W + FRAC_BITS;
   localparam int CntW = $clog2(DW + 1);

   logic [DW-1:0]              quo_ff, quo_in;
   logic [kldg_pkg::IN_W-1:0]  rem_ff, rem_in;
   logic [kldg_pkg::IN_W-1:0]  dsr_ff, dsr_in;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic [kldg_pkg::IN_W:0]    trial;
   logic                       fits;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[DW-1]};
      fits   = trial >= {1'b0, dsr_ff};
      if (start) begin
         quo_in = {dividend_p, {FRAC_BITS{1'b0}}};
         rem_in = '0;
         dsr_in = divisor_q;
         cnt_in = CntW'(DW);
      end else if (cnt_ff != '0) begin
         // partial remainder stays below the divisor, so 16 bits hold it
         rem_in = fits ? kldg_pkg::IN_W'(trial - {1'b0, dsr_ff}) : trial[kldg_pkg::IN_W-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = (cnt_ff == '0);

endmodule

`default_nettype wire

### rtl/kldg_ctrl.sv
// kldg_ctrl: sequencer for one word: log of P, log of Q, multiply, divider wait, commit.
// Zero P or Q skips to commit. Depends on kldg_pkg for state, command and status types.
`default_nettype none

module kldg_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kldg_pkg::sts_type sts,
   output kldg_pkg::cmd_type      cmd
);

   kldg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kldg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         kldg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kldg_pkg::ST_LNP;
            end
         end
         kldg_pkg::ST_LNP: begin
            cmd.ln_p = 1'b1;
            state_in = sts.skip ? kldg_pkg::ST_DONE : kldg_pkg::ST_LNQ;
         end
         kldg_pkg::ST_LNQ: begin
            cmd.ln_q = 1'b1;
            state_in = kldg_pkg::ST_MUL;
         end
         kldg_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = kldg_pkg::ST_DIV;
         end
         kldg_pkg::ST_DIV: begin
            if (sts.div_done) begin
               state_in = kldg_pkg::ST_DONE;
            end
         end
         kldg_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = kldg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kldg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/kldg_dp.sv
// kldg_dp: operand registers, table log unit, multiplier, loss accumulator, result register.
// Depends on kldg_pkg and kldg_div.
`default_nettype none

module kldg_dp #(
   parameter int LN_TABLE_BITS = kldg_pkg::LN_TABLE_BITS_DEF,
   parameter int FRAC_BITS     = kldg_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire kldg_pkg::cmd_type                   cmd,
   output kldg_pkg::sts_type                        sts,
   input  wire logic [kldg_pkg::IN_W-1:0]           req_target_p,
   input  wire logic [kldg_pkg::IN_W-1:0]           req_predicted_q,
   input  wire logic                                req_last,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic signed [kldg_pkg::GRAD_W-1:0]       rsp_grad,
   output logic signed [kldg_pkg::LOSS_W-1:0]       rsp_loss,
   output logic                                     rsp_loss_valid,
   output logic                                     rsp_zero_q
);

   localparam int TabSize = 1 << LN_TABLE_BITS;
   localparam int DW      = kldg_pkg::IN_W + FRAC_BITS;
   localparam int QW      = (DW > 32) ? DW : 33;

   // operand registers
   logic [kldg_pkg::IN_W-1:0] p_ff, q_ff;
   logic                      last_ff;

   // log unit
   logic [kldg_pkg::TAB_W-1:0]        ln_tab [TabSize];
   logic [kldg_pkg::IN_W-1:0]         ln_v;
   logic [3:0]                        ln_e;
   logic [LN_TABLE_BITS-1:0]          ln_idx;
   logic signed [5:0]                 ln_em;
   logic signed [30:0]                ln_eterm;
   logic signed [kldg_pkg::LN_W-1:0]  ln_val;
   logic signed [kldg_pkg::LN_W-1:0]  lnp_ff, diff_ff;

   // multiply and accumulate
   logic signed [kldg_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [kldg_pkg::TERM_W-1:0] term;
   logic signed [kldg_pkg::LOSS_W:0]   acc;
   logic signed [kldg_pkg::LOSS_W-1:0] sum_ff, sum_in, sum_new;
   logic                               seen_ff, seen_in, seen_new;

   // divider and gradient
   logic [DW-1:0]                 quo;
   logic                          div_done;
   logic [QW-1:0]                 quo_ext;
   logic [kldg_pkg::GRAD_W-1:0]   grad_mag, grad_val;
   logic                          p_nz, q_z;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [kldg_pkg::GRAD_W-1:0] rsp_grad_ff;
   logic signed [kldg_pkg::LOSS_W-1:0] rsp_loss_ff;
   logic                               rsp_lv_ff, rsp_zq_ff;

   for (genvar k = 0; k < TabSize; k++) begin : g_tab
      localparam logic [kldg_pkg::TAB_W-1:0] Entry =
         kldg_pkg::ln_entry(k, LN_TABLE_BITS);
      assign ln_tab[k] = Entry;
   end

   kldg_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.load),
      .dividend_p (req_target_p),
      .divisor_q  (req_predicted_q),
      .quotient   (quo),
      .done       (div_done)
   );

   // ln(v) = (e - 15) * ln2 + ln(mantissa), mantissa bits just below the top one
   always_comb begin
      ln_v = cmd.ln_q ? q_ff : p_ff;
      ln_e = '0;
      for (int i = 0; i < kldg_pkg::IN_W; i++) begin
         if (ln_v[i]) begin
            ln_e = 4'(i);
         end
      end
      ln_idx   = LN_TABLE_BITS'({ln_v, {LN_TABLE_BITS{1'b0}}} >> ln_e);
      ln_em    = $signed({2'b00, ln_e}) - 6'sd15;
      ln_eterm = 31'(ln_em) * $signed(31'(kldg_pkg::LN2_Q24));
      ln_val   = kldg_pkg::LN_W'(ln_eterm)
               + $signed({{(kldg_pkg::LN_W-kldg_pkg::TAB_W){1'b0}}, ln_tab[ln_idx]});
   end

   always_comb begin
      prod_in = kldg_pkg::PROD_W'($signed({1'b0, p_ff})) * kldg_pkg::PROD_W'(diff_ff);
      // arithmetic shift rounds toward minus infinity
      term    = kldg_pkg::TERM_W'(prod_ff >>> kldg_pkg::IN_FRAC);
      acc     = (kldg_pkg::LOSS_W+1)'(term) + (kldg_pkg::LOSS_W+1)'(sum_ff);
   end

   always_comb begin
      p_nz     = (p_ff != '0);
      q_z      = (q_ff == '0);
      quo_ext  = QW'(quo);
      grad_mag = (quo_ext > (QW'(1) << 31)) ? kldg_pkg::GRAD_MIN : quo_ext[31:0];
      if (!p_nz) begin
         grad_val = '0;
      end else if (q_z) begin
         grad_val = kldg_pkg::GRAD_MIN;
      end else begin
         grad_val = kldg_pkg::GRAD_W'(0) - grad_mag;
      end

      seen_new = seen_ff | (p_nz & q_z);
      sum_new  = sum_ff;
      if (p_nz && !q_z && !seen_ff) begin
         if (acc[kldg_pkg::LOSS_W] != acc[kldg_pkg::LOSS_W-1]) begin
            sum_new = acc[kldg_pkg::LOSS_W] ? kldg_pkg::LOSS_MIN : kldg_pkg::LOSS_MAX;
         end else begin
            sum_new = acc[kldg_pkg::LOSS_W-1:0];
         end
      end
      if (seen_new) begin
         sum_new = kldg_pkg::LOSS_MAX;
      end

      sum_in  = sum_ff;
      seen_in = seen_ff;
      if (cmd.commit) begin
         sum_in  = last_ff ? '0 : sum_new;
         seen_in = last_ff ? 1'b0 : seen_new;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff    <= req_target_p;
         q_ff    <= req_predicted_q;
         last_ff <= req_last;
      end
      if (cmd.ln_p) begin
         lnp_ff <= ln_val;
      end
      if (cmd.ln_q) begin
         diff_ff <= lnp_ff - ln_val;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.commit) begin
         rsp_grad_ff <= grad_val;
         rsp_loss_ff <= last_ff ? sum_new : '0;
         rsp_lv_ff   <= last_ff;
         rsp_zq_ff   <= seen_new;
      end
      if (reset) begin
         sum_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.skip     = (p_ff == '0) || (q_ff == '0);
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grad       = rsp_grad_ff;
   assign rsp_loss       = rsp_loss_ff;
   assign rsp_loss_valid = rsp_lv_ff;
   assign rsp_zero_q     = rsp_zq_ff;

`ifndef SYNTHESIS
   // a zero Q with P nonzero pins the running loss at its ceiling until the tensor ends
   a_seen_pins_sum: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (sum_ff == kldg_pkg::LOSS_MAX))
      else $error("loss sum not saturated after zero Q");

   a_loss_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_lv_ff) |-> (rsp_loss_ff == '0))
      else $error("loss reported on a word that is not last");

   a_commit_after_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !sts.skip) |-> div_done)
      else $error("result committed before quotient ready");
`endif

endmodule

`default_nettype wire

### rtl/kl_divergence_loss_grad.sv
// kl_divergence_loss_grad: top level; joins the sequencer and the datapath.
// Depends on kldg_pkg, kldg_ctrl, kldg_dp (which holds kldg_div).
//
//   channel  direction  handshake           word
//   req_     in         req_valid/req_stall target_p, predicted_q, last
//   rsp_     out        rsp_valid/rsp_stall grad, loss, loss_valid, zero_q
//
// One word at a time. A word with P and Q nonzero goes through log of P, log of Q, multiply
// and a wait on the divider, which makes one quotient bit per cycle, before its result.
// A word with P or Q zero goes from log of P straight to the commit of its result.
// The next word can be taken in the cycle after the commit.
// Synchronous active-high reset clears the running loss, the zero-Q flag and both
// handshakes. A new word is taken while the last result still waits on rsp_stall;
// the commit of a word waits only for the result register to free up.
`default_nettype none

module kl_divergence_loss_grad #(
   parameter int LN_TABLE_BITS = kldg_pkg::LN_TABLE_BITS_DEF,
   parameter int FRAC_BITS     = kldg_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [kldg_pkg::IN_W-1:0]          req_target_p,
   input  wire logic [kldg_pkg::IN_W-1:0]          req_predicted_q,
   input  wire logic                               req_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [kldg_pkg::GRAD_W-1:0]      rsp_grad,
   output logic signed [kldg_pkg::LOSS_W-1:0]      rsp_loss,
   output logic                                    rsp_loss_valid,
   output logic                                    rsp_zero_q
);

   kldg_pkg::cmd_type cmd;
   kldg_pkg::sts_type sts;

   kldg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kldg_dp #(
      .LN_TABLE_BITS (LN_TABLE_BITS),
      .FRAC_BITS     (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_target_p    (req_target_p),
      .req_predicted_q (req_predicted_q),
      .req_last        (req_last),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_grad        (rsp_grad),
      .rsp_loss        (rsp_loss),
      .rsp_loss_valid  (rsp_loss_valid),
      .rsp_zero_q      (rsp_zero_q)
   );

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word taken while one is in progress");

   a_grad_nonpos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_grad[kldg_pkg::GRAD_W-1] || (rsp_grad == '0)))
      else $error("positive gradient");
`endif

endmodule

`default_nettype wire

### tb/sv/kl_divergence_loss_grad_chk.sv
// kl_divergence_loss_grad_chk: watches the req_ and rsp_ channels of the KL loss block,
// predicts each result word and compares it field by field with the word the block gives.
// Depends on kldg_pkg for widths and constants.
module kl_divergence_loss_grad_chk (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic [kldg_pkg::IN_W-1:0]           req_target_p,
   input  wire logic [kldg_pkg::IN_W-1:0]           req_predicted_q,
   input  wire logic                                req_last,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic signed [kldg_pkg::GRAD_W-1:0]  rsp_grad,
   input  wire logic signed [kldg_pkg::LOSS_W-1:0]  rsp_loss,
   input  wire logic                                rsp_loss_valid,
   input  wire logic                                rsp_zero_q,
   output int                                       fail_count,
   output int                                       pending_words
);
   import kldg_pkg::*;

   localparam int     TAB_BITS  = LN_TABLE_BITS_DEF;
   localparam int     GRAD_FRAC = FRAC_BITS_DEF;
   localparam longint SUM_HI    = (64'sd1 <<< (LOSS_W - 1)) - 1;
   localparam longint SUM_LO    = -(64'sd1 <<< (LOSS_W - 1));

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad;
      logic signed [LOSS_W-1:0] loss;
      logic                     loss_valid;
      logic                     zero_q;
   } kl_word_type;

   longint      ln_mant_q24 [1 << TAB_BITS];
   longint      running_loss;
   bit          saw_zero_q;
   kl_word_type expected_words [$];

   // ln(1 + k/2^TAB_BITS) in Q24: log2 by repeated squaring, then times ln 2
   function automatic longint ln_mantissa(input int unsigned k);
      longint unsigned y;
      longint unsigned r;
      y = (64'd1 << 30) + (64'(k) << (30 - TAB_BITS));
      r = 0;
      repeat (28) begin
         y = (y * y) >> 30;
         r = r << 1;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            r = r | 64'd1;
         end
      end
      return longint'((r * 64'(LN2_Q32) + (64'd1 << 35)) >> 36);
   endfunction

   // ln(v / 2^15) in Q24, v nonzero
   function automatic longint ln_q24_of(input logic [IN_W-1:0] v);
      int          e;
      int unsigned idx;
      e = IN_W - 1;
      while (e > 0 && !v[e])
         e--;
      if (e >= TAB_BITS)
         idx = (32'(v) >> (e - TAB_BITS)) & ((1 << TAB_BITS) - 1);
      else
         idx = (32'(v) << (TAB_BITS - e)) & ((1 << TAB_BITS) - 1);
      return longint'(e - IN_FRAC) * longint'(LN2_Q24) + ln_mant_q24[idx];
   endfunction

   function automatic kl_word_type predict_kl_word(input logic [IN_W-1:0] p, q,
                                                   input logic last);
      kl_word_type     w;
      longint unsigned quo;
      longint          term;
      longint          total;
      w = '0;
      if (p != 0) begin
         if (q == 0) begin
            saw_zero_q = 1'b1;
            w.grad = GRAD_MIN;
         end else begin
            quo = (64'(p) << GRAD_FRAC) / 64'(q);
            if (quo > (64'd1 << 31))
               quo = 64'd1 << 31;
            w.grad = GRAD_W'(64'd0 - quo);
            // arithmetic shift floors toward minus infinity
            term = (longint'(p) * (ln_q24_of(p) - ln_q24_of(q))) >>> IN_FRAC;
            if (!saw_zero_q) begin
               total = running_loss + term;
               if (total > SUM_HI)
                  total = SUM_HI;
               if (total < SUM_LO)
                  total = SUM_LO;
               running_loss = total;
            end
         end
      end
      // a zero Q with P nonzero pins the sum at its top for the rest of the tensor
      if (saw_zero_q)
         running_loss = SUM_HI;
      w.loss_valid = last;
      w.zero_q = saw_zero_q;
      if (last) begin
         w.loss = running_loss[LOSS_W-1:0];
         running_loss = 0;
         saw_zero_q = 1'b0;
      end
      return w;
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] want, got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_words = 0;
      running_loss = 0;
      saw_zero_q = 1'b0;
      for (int k = 0; k < (1 << TAB_BITS); k++)
         ln_mant_q24[k] = ln_mantissa(k);
   end

   always @(posedge clock) begin
      kl_word_type want;
      if (reset) begin
         expected_words.delete();
         running_loss = 0;
         saw_zero_q = 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_words.push_back(predict_kl_word(req_target_p, req_predicted_q, req_last));
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with no word pending: grad %0d loss %0d",
                      rsp_grad, rsp_loss);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("grad", want.grad, rsp_grad);
               check_field("loss", want.loss, rsp_loss);
               check_field("loss_valid", want.loss_valid, rsp_loss_valid);
               check_field("zero_q", want.zero_q, rsp_zero_q);
            end
         end
      end
      pending_words = expected_words.size();
   end

endmodule

### tb/sv/kl_divergence_loss_grad_tb.sv
// kl_divergence_loss_grad_tb: drives P/Q word streams into the KL loss block with bursty
// sending and patterned result stalls; checking is done by kl_divergence_loss_grad_chk.
// Depends on kldg_pkg, the block's RTL and the checker.
module kl_divergence_loss_grad_tb;
   import kldg_pkg::*;

   localparam int TOTAL_WORDS    = 950;
   localparam int DRAIN_CYCLES   = 48;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [IN_W-1:0]          req_target_p;
   logic [IN_W-1:0]          req_predicted_q;
   logic                     req_last;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [GRAD_W-1:0] rsp_grad;
   logic signed [LOSS_W-1:0] rsp_loss;
   logic                     rsp_loss_valid;
   logic                     rsp_zero_q;
   int                       fail_count;
   int                       pending_words;

   int             burst_left = 0;
   int             words_sent = 0;
   int             stall_cycle = 0;
   stall_mode_type stall_mode = STALL_NONE;

   kl_divergence_loss_grad u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_target_p    (req_target_p),
      .req_predicted_q (req_predicted_q),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_grad        (rsp_grad),
      .rsp_loss        (rsp_loss),
      .rsp_loss_valid  (rsp_loss_valid),
      .rsp_zero_q      (rsp_zero_q)
   );

   kl_divergence_loss_grad_chk u_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_target_p    (req_target_p),
      .req_predicted_q (req_predicted_q),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_grad        (rsp_grad),
      .rsp_loss        (rsp_loss),
      .rsp_loss_valid  (rsp_loss_valid),
      .rsp_zero_q      (rsp_zero_q),
      .fail_count      (fail_count),
      .pending_words   (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: stall pattern picked at random among none, light, heavy and periodic
   always @(negedge clock) begin
      if (stall_cycle % 200 == 0)
         stall_mode = stall_mode_type'($urandom_range(0, 3));
      stall_cycle++;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= ((stall_cycle % 16) < 10);
      endcase
   end

   function automatic logic [IN_W-1:0] corner_value();
      case ($urandom_range(0, 4))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'd32767;
         3:       return 16'd32768;
         default: return 16'd65535;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic [IN_W-1:0] p, q, input logic last);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 12);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_target_p    <= p;
      req_predicted_q <= q;
      req_last        <= last;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("kl_divergence_loss_grad_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int               tensor_len;
      int               pick;
      bit               paused;
      logic [IN_W-1:0]  p;
      logic [IN_W-1:0]  q;
      reset = 1'b1;
      req_valid = 1'b0;
      req_target_p = '0;
      req_predicted_q = '0;
      req_last = 1'b0;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero P, unity and extreme ratios, values above 1.0
      send_word(16'd0, 16'd0, 1'b0);
      send_word(16'd0, 16'd32768, 1'b0);
      send_word(16'd32768, 16'd32768, 1'b0);
      send_word(16'd1, 16'd65535, 1'b0);
      send_word(16'd65535, 16'd1, 1'b0);
      send_word(16'd32768, 16'd1, 1'b0);
      send_word(16'd1, 16'd1, 1'b0);
      send_word(16'd16384, 16'd32768, 1'b1);
      // single-word tensors
      send_word(16'd32768, 16'd32768, 1'b1);
      send_word(16'd0, 16'd0, 1'b1);
      // zero Q with P nonzero: later terms are ignored, sum pinned high
      send_word(16'd12345, 16'd0, 1'b0);
      send_word(16'd20000, 16'd10000, 1'b0);
      send_word(16'd0, 16'd0, 1'b1);
      send_word(16'd100, 16'd200, 1'b0);
      send_word(16'd5000, 16'd0, 1'b1);
      // flag must be clear again in the next tensor
      send_word(16'd65535, 16'd65535, 1'b0);
      send_word(16'd0, 16'd65535, 1'b0);
      send_word(16'd65535, 16'd32768, 1'b1);
      send_word(16'd1, 16'd32768, 1'b1);
      // top bit below the table index width
      send_word(16'd3, 16'd200, 1'b0);
      send_word(16'd200, 16'd3, 1'b0);
      send_word(16'd65535, 16'd0, 1'b0);
      send_word(16'd65535, 16'd32767, 1'b1);
      wait_for_results();

      while (words_sent < TOTAL_WORDS) begin
         tensor_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
         for (int i = 0; i < tensor_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               p = IN_W'($urandom_range(0, 32768));
               q = IN_W'($urandom_range(1, 32768));
            end else if (pick < 70) begin
               p = IN_W'($urandom_range(0, 65535));
               q = IN_W'($urandom_range(0, 65535));
            end else if (pick < 80) begin
               p = IN_W'($urandom_range(0, 255));
               q = IN_W'($urandom_range(1, 255));
            end else if (pick < 88) begin
               p = 16'd0;
               q = IN_W'($urandom_range(0, 65535));
            end else if (pick < 90) begin
               p = IN_W'($urandom_range(1, 65535));
               q = 16'd0;
            end else begin
               p = corner_value();
               q = corner_value();
            end
            send_word(p, q, i == tensor_len - 1);
         end
         if (!paused && words_sent >= TOTAL_WORDS / 2) begin
            paused = 1'b1;
            wait_for_results();
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("kl_divergence_loss_grad_tb OK");
      else
         $display("kl_divergence_loss_grad_tb NOT OK");
      $finish;
   end

endmodule
